>>> hdl/jcr_pkg.sv
package jcr_pkg;

  localparam int REPORT_LEN  = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_REPLY   = 10;
  localparam int IDX_W       = $clog2(MAX_REPLY);

  // host command bytes
  localparam logic [7:0] CMD_PROBE  = 8'h00;
  localparam logic [7:0] CMD_POLL   = 8'h40;
  localparam logic [7:0] CMD_ORIGIN = 8'h41;

  // reply bytes
  localparam logic [7:0] PROBE_ID_HI  = 8'h09;
  localparam logic [7:0] PROBE_ID_LO  = 8'h03;
  localparam logic [7:0] ORIGIN_AXIS  = 8'h80;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] STICK_CENTER = 8'd127;

  localparam logic [REPORT_LEN*8-1:0] REPORT_RESET =
    {BYTE_ZERO, BYTE_ZERO, STICK_CENTER, STICK_CENTER,
     STICK_CENTER, STICK_CENTER, BYTE_ZERO, BYTE_ZERO};

  // reply kinds
  localparam logic [1:0] KIND_PROBE  = 2'd0;
  localparam logic [1:0] KIND_ORIGIN = 2'd1;
  localparam logic [1:0] KIND_POLL   = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [REPORT_LEN*8-1:0] data;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic empty;
    job_t head;
  } head_t;

  function automatic logic [IDX_W-1:0] reply_last_idx(input logic [1:0] kind);
    logic [IDX_W-1:0] r;
    case (kind)
      KIND_PROBE:  r = IDX_W'(2);
      KIND_ORIGIN: r = IDX_W'(MAX_REPLY - 1);
      default:     r = IDX_W'(REPORT_LEN - 1);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] reply_byte(input job_t job, input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (job.kind)
      KIND_PROBE: begin
        case (idx)
          IDX_W'(0): b = PROBE_ID_HI;
          IDX_W'(2): b = PROBE_ID_LO;
          default:   b = BYTE_ZERO;
        endcase
      end
      KIND_ORIGIN: begin
        b = (idx >= IDX_W'(1) && idx <= IDX_W'(5)) ? ORIGIN_AXIS : BYTE_ZERO;
      end
      default: begin
        b = job.data[{idx[2:0], 3'b000} +: 8];
      end
    endcase
    return b;
  endfunction

endpackage

>>> hdl/jcr_front.sv
module jcr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         op,
  input  logic [7:0]                   rx_byte,
  input  logic [jcr_pkg::REPORT_LEN*8-1:0] report,
  output jcr_pkg::push_t               push
);

  logic                              awaiting_args;
  logic [1:0]                        args_left;
  logic [jcr_pkg::REPORT_LEN*8-1:0]  report_store;
  logic [1:0]                        args_dec;

  assign args_dec = args_left - 2'd1;

  always_comb begin
    push.valid    = 1'b0;
    push.job.kind = jcr_pkg::KIND_POLL;
    push.job.data = report_store;
    if (accept && !op) begin
      if (awaiting_args) begin
        push.valid = (args_dec == 2'd0);
      end else begin
        unique case (rx_byte)
          jcr_pkg::CMD_PROBE: begin
            push.valid    = 1'b1;
            push.job.kind = jcr_pkg::KIND_PROBE;
          end
          jcr_pkg::CMD_ORIGIN: begin
            push.valid    = 1'b1;
            push.job.kind = jcr_pkg::KIND_ORIGIN;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_args <= 1'b0;
      args_left     <= 2'd3;
      report_store  <= jcr_pkg::REPORT_RESET;
    end else if (accept) begin
      if (op) begin
        report_store <= report;
      end else if (awaiting_args) begin
        args_left <= args_dec;
        if (args_dec == 2'd0) awaiting_args <= 1'b0;
      end else if (rx_byte == jcr_pkg::CMD_POLL) begin
        awaiting_args <= 1'b1;
        args_left     <= 2'd2;
      end
    end
  end

endmodule

>>> hdl/jcr_queue.sv
module jcr_queue #(
  parameter int DEPTH = jcr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  jcr_pkg::push_t  push,
  input  logic            pop,
  output jcr_pkg::head_t  head,
  output logic            full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  jcr_pkg::job_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.empty = (count == '0);
  assign head.head  = entries[rd_ptr];
  assign do_pop     = pop && !head.empty;

  always_ff @(posedge clk) begin
    if (push.valid) entries[wr_ptr] <= push.job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)     rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push.valid && !do_pop)      count <= count + 1'b1;
      else if (!push.valid && do_pop) count <= count - 1'b1;
    end
  end

endmodule

>>> hdl/jcr_back.sv
module jcr_back (
  input  logic            clk,
  input  logic            rst,
  input  jcr_pkg::head_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      tx_byte,
  output logic            last
);

  logic [jcr_pkg::IDX_W-1:0] idx;
  logic                      load;
  logic                      at_end;

  assign load   = !head.empty && (!out_valid || !out_stall);
  assign at_end = (idx == jcr_pkg::reply_last_idx(head.head.kind));
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte <= jcr_pkg::reply_byte(head.head, idx);
      last    <= at_end;
    end
  end

endmodule

>>> hdl/joybus_controller_responder_core.sv
// A command is queued, then the back end registers its first reply byte. Throughput: one
// input transaction per cycle while the reply queue has room; the byte sequencer in the
// back end sends one reply byte per cycle while out_stall is low. A reply is 3, 8 or 10
// bytes long. Queue depth sets how far the front runs ahead.
// Reset (rst, synchronous, active high): queue and output empty, no argument wait,
// report store back to centered sticks and zero buttons and triggers.
module joybus_controller_responder_core #(
  parameter int QUEUE_DEPTH = jcr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  logic [7:0] buttons_first,
  input  logic [7:0] buttons_second,
  input  logic [7:0] left_x,
  input  logic [7:0] left_y,
  input  logic [7:0] right_x,
  input  logic [7:0] right_y,
  input  logic [7:0] trigger_left,
  input  logic [7:0] trigger_right,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last
);

  jcr_pkg::push_t                    push;
  jcr_pkg::head_t                    head;
  logic                              queue_full;
  logic                              pop;
  logic                              accept;
  logic [jcr_pkg::REPORT_LEN*8-1:0]  report;

  // Stall the input side whenever the queue is full; report updates wait
  // along with host bytes.
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // Byte k of the report sits at bits [8k+7:8k].
  assign report = {trigger_right, trigger_left, right_y, right_x,
                   left_y, left_x, buttons_second, buttons_first};

  // Front: decode commands, count poll arguments, keep the report store.
  // A poll job carries a snapshot of the store, so later updates do not
  // disturb a reply already queued.
  jcr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (op),
    .rx_byte (rx_byte),
    .report  (report),
    .push    (push)
  );

  // Queue of reply jobs between decode and byte sequencing.
  jcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (queue_full)
  );

  // Back: walk the head job byte by byte into the output register; drop the
  // job from the queue as its final byte is loaded.
  jcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .last      (last)
  );

endmodule

>>> test/joybus_controller_responder_core_test.sv
`timescale 1ns / 100ps

module joybus_controller_responder_core_test;

  // Item kinds on the input channel
  localparam logic OP_HOST_BYTE = 1'b0;
  localparam logic OP_REPORT    = 1'b1;

  // Typed reply count that means "take the reply from the predictor"
  localparam logic [3:0] PREDICTED = 4'hF;

  // Fixed replies, first byte in the top bits
  localparam logic [23:0] PROBE_BYTES  = 24'h09_00_03;
  localparam logic [79:0] ORIGIN_BYTES = 80'h00_80_80_80_80_80_00_00_00_00;

  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // One row of the directed table: the transaction and, where it is obvious,
  // the reply typed in by hand (typed_n bytes, first byte in the top bits).
  typedef struct packed {
    logic        op;
    logic [7:0]  rx;
    logic [63:0] report;
    logic [3:0]  typed_n;
    logic [79:0] typed;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       op;
  logic [7:0] rx_byte;
  logic [7:0] buttons_first;
  logic [7:0] buttons_second;
  logic [7:0] left_x;
  logic [7:0] left_y;
  logic [7:0] right_x;
  logic [7:0] right_y;
  logic [7:0] trigger_left;
  logic [7:0] trigger_right;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] tx_byte;
  logic       last;

  // Hand-typed reply that travels with the current input transaction
  logic [3:0]  typed_count;
  logic [79:0] typed_reply;

  // Predictor state: argument wait of the poll command and the stored report
  logic       poll_wait;
  logic [1:0] poll_args_left;
  logic [7:0] report_bytes [0:7];

  reply_byte_t fresh_reply[$];    // reply worked out for the latest transaction
  reply_byte_t pending_reply[$];  // reply bytes still owed by the block

  int  mismatches = 0;
  int  cycle_count = 0;
  int  useful_items = 0;
  bit  long_hold_req = 0;
  bit  no_gaps = 0;
  bit  steady_phase = 0;
  bit  sender_idles = 1;

  joybus_controller_responder_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .rx_byte        (rx_byte),
    .buttons_first  (buttons_first),
    .buttons_second (buttons_second),
    .left_x         (left_x),
    .left_y         (left_y),
    .right_x        (right_x),
    .right_y        (right_y),
    .trigger_left   (trigger_left),
    .trigger_right  (trigger_right),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tx_byte        (tx_byte),
    .last           (last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed table. Replies are typed only where they follow at a glance:
  // fixed probe and origin replies, polls of the reset store and of all-zero
  // or all-one reports, and commands that must stay silent.
  function automatic stim_row_t directed_row(input int idx);
    stim_row_t r;
    case (idx)
      // fixed replies straight after reset
      0:  r = {OP_HOST_BYTE, jcr_pkg::CMD_PROBE, 64'h0, 4'd3, PROBE_BYTES, 56'h0};
      1:  r = {OP_HOST_BYTE, jcr_pkg::CMD_ORIGIN, 64'h0, 4'd10, ORIGIN_BYTES};
      // poll of the reset store; a command code used as an argument is only an argument
      2:  r = {OP_HOST_BYTE, jcr_pkg::CMD_POLL, 64'h0, 4'd0, 80'h0};
      3:  r = {OP_HOST_BYTE, jcr_pkg::CMD_PROBE, 64'h0, 4'd0, 80'h0};
      4:  r = {OP_HOST_BYTE, 8'hFF, 64'h0, 4'd8, 80'h00_00_7F_7F_7F_7F_00_00_00_00};
      // all-ones report
      5:  r = {OP_REPORT, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 80'h0};
      6:  r = {OP_HOST_BYTE, jcr_pkg::CMD_POLL, 64'h0, 4'd0, 80'h0};
      7:  r = {OP_HOST_BYTE, jcr_pkg::CMD_ORIGIN, 64'h0, 4'd0, 80'h0};
      8:  r = {OP_HOST_BYTE, jcr_pkg::CMD_POLL, 64'h0, 4'd8, 80'hFF_FF_FF_FF_FF_FF_FF_FF_00_00};
      // all-zero report
      9:  r = {OP_REPORT, 8'h00, 64'h0, 4'd0, 80'h0};
      10: r = {OP_HOST_BYTE, jcr_pkg::CMD_POLL, 64'h0, 4'd0, 80'h0};
      11: r = {OP_HOST_BYTE, 8'h00, 64'h0, 4'd0, 80'h0};
      12: r = {OP_HOST_BYTE, 8'hFF, 64'h0, 4'd8, 80'h0};
      // unknown commands stay silent
      13: r = {OP_HOST_BYTE, 8'hFF, 64'h0, 4'd0, 80'h0};
      14: r = {OP_HOST_BYTE, 8'h01, 64'h0, 4'd0, 80'h0};
      15: r = {OP_HOST_BYTE, 8'h42, 64'h0, 4'd0, 80'h0};
      16: r = {OP_HOST_BYTE, 8'h80, 64'h0, 4'd0, 80'h0};
      // report update between the two poll arguments: the reply uses the new bytes
      17: r = {OP_HOST_BYTE, jcr_pkg::CMD_POLL, 64'h0, 4'd0, 80'h0};
      18: r = {OP_HOST_BYTE, 8'h12, 64'h0, 4'd0, 80'h0};
      19: r = {OP_REPORT, 8'h5A, 64'hA5_5A_01_FE_80_7F_C3_3C, PREDICTED, 80'h0};
      20: r = {OP_HOST_BYTE, 8'h34, 64'h0, PREDICTED, 80'h0};
      21: r = {OP_REPORT, 8'hC3, 64'h01_23_45_67_89_AB_CD_EF, PREDICTED, 80'h0};
      22: r = {OP_HOST_BYTE, jcr_pkg::CMD_POLL, 64'h0, PREDICTED, 80'h0};
      23: r = {OP_HOST_BYTE, 8'h7F, 64'h0, PREDICTED, 80'h0};
      default: r = {OP_HOST_BYTE, 8'h80, 64'h0, PREDICTED, 80'h0};
    endcase
    return r;
  endfunction

  function automatic logic [63:0] random_report();
    logic [63:0] r;
    case ($urandom_range(0, 5))
      0:       r = 64'h0;
      1:       r = 64'hFFFF_FFFF_FFFF_FFFF;
      default: r = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  task automatic queue_reply_byte(input logic [7:0] data, input logic is_last);
    reply_byte_t b;
    b.data = data;
    b.last = is_last;
    fresh_reply.push_back(b);
  endtask

  // Decode one transaction the way the responder does and collect its reply.
  task automatic decode_host_item(input logic item_op, input logic [7:0] item_rx,
                                  input logic [63:0] item_report);
    int k;
    fresh_reply.delete();
    if (item_op == OP_REPORT) begin
      // store all eight bytes; an argument wait in progress is untouched
      for (k = 0; k < 8; k++) report_bytes[k] = item_report[63 - 8*k -: 8];
    end else if (poll_wait) begin
      // any host byte counts as an argument, whatever its value
      poll_args_left = poll_args_left - 2'd1;
      if (poll_args_left == 2'd0) begin
        poll_wait = 1'b0;
        for (k = 0; k < 8; k++) queue_reply_byte(report_bytes[k], k == 7);
      end
    end else begin
      case (item_rx)
        jcr_pkg::CMD_PROBE:
          for (k = 0; k < 3; k++) queue_reply_byte(PROBE_BYTES[23 - 8*k -: 8], k == 2);
        jcr_pkg::CMD_ORIGIN:
          for (k = 0; k < 10; k++) queue_reply_byte(ORIGIN_BYTES[79 - 8*k -: 8], k == 9);
        jcr_pkg::CMD_POLL: begin
          poll_wait      = 1'b1;
          poll_args_left = 2'd2;
        end
        default: ;  // unknown command: drop it
      endcase
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("cycle %0d: %s", cycle_count, msg);
  endtask

  // Check every reply byte against the oldest one owed, then predict the reply
  // of any input transaction taken at this edge. Both happen in one block so
  // the order within the edge is fixed.
  always @(posedge clk) begin
    reply_byte_t want;
    int k;
    if (rst) begin
      poll_wait      <= 1'b0;
      poll_args_left <= 2'd3;
      for (k = 0; k < 8; k++) report_bytes[k] <= (k >= 2 && k <= 5) ? 8'd127 : 8'd0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reply.size() == 0) begin
          flag_mismatch($sformatf("unexpected reply byte %h (last %b)", tx_byte, last));
        end else begin
          want = pending_reply.pop_front();
          if (tx_byte !== want.data)
            flag_mismatch($sformatf("tx_byte expected %h, got %h", want.data, tx_byte));
          if (last !== want.last)
            flag_mismatch($sformatf("last expected %b, got %b (tx_byte %h)",
                                    want.last, last, tx_byte));
        end
      end
      if (in_valid && !in_stall) begin
        decode_host_item(op, rx_byte, {buttons_first, buttons_second, left_x, left_y,
                                       right_x, right_y, trigger_left, trigger_right});
        if (typed_count == PREDICTED) begin
          foreach (fresh_reply[k]) pending_reply.push_back(fresh_reply[k]);
        end else begin
          for (k = 0; k < typed_count; k++) begin
            want.data = typed_reply[79 - 8*k -: 8];
            want.last = (k == typed_count - 1);
            pending_reply.push_back(want);
          end
        end
      end
    end
  end

  // Watchdog: end a hung run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall in random bursts, leave calm stretches, and hold off for a
  // long stretch when the sender asks for it.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if (!steady_phase && (cycle_count / 300) % 4 != 3 &&
                   $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one transaction at the falling edge, hold it until taken, then maybe
  // idle for a random burst.
  task automatic send_item(input logic item_op, input logic [7:0] item_rx,
                           input logic [63:0] item_report, input logic [3:0] item_n,
                           input logic [79:0] item_typed);
    int gap;
    op          = item_op;
    rx_byte     = item_rx;
    {buttons_first, buttons_second, left_x, left_y,
     right_x, right_y, trigger_left, trigger_right} = item_report;
    typed_count = item_n;
    typed_reply = item_typed;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!no_gaps && !steady_phase && sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_host_byte(input logic [7:0] b);
    send_item(OP_HOST_BYTE, b, random_report(), PREDICTED, 80'h0);
  endtask

  // Mostly well-formed command sequences with random content, plus noise
  // (unknown commands) and broken polls that leave an argument missing.
  task automatic send_random_sequence();
    int pick;
    logic [7:0] noise;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_item(OP_REPORT, 8'($urandom), random_report(), PREDICTED, 80'h0);
      useful_items++;
    end else if (pick < 35) begin
      send_host_byte(jcr_pkg::CMD_PROBE);
      useful_items++;
    end else if (pick < 50) begin
      send_host_byte(jcr_pkg::CMD_ORIGIN);
      useful_items++;
    end else if (pick < 80) begin
      send_host_byte(jcr_pkg::CMD_POLL);
      send_host_byte(8'($urandom));
      if ($urandom_range(0, 5) == 0) begin
        send_item(OP_REPORT, 8'($urandom), random_report(), PREDICTED, 80'h0);
        useful_items++;
      end
      send_host_byte(8'($urandom));
      useful_items += 3;
    end else if (pick < 90) begin
      do noise = 8'($urandom);
      while (noise == jcr_pkg::CMD_PROBE || noise == jcr_pkg::CMD_POLL ||
             noise == jcr_pkg::CMD_ORIGIN);
      send_host_byte(noise);
    end else begin
      // broken poll: one argument only, the next byte completes it
      send_host_byte(jcr_pkg::CMD_POLL);
      send_host_byte(8'($urandom));
      useful_items += 2;
    end
  endtask

  initial begin
    stim_row_t row;
    int row_idx;
    bit hold_done;
    bit drain_done;
    hold_done      = 0;
    drain_done     = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_HOST_BYTE;
    rx_byte        = 8'h00;
    buttons_first  = 8'h00;
    buttons_second = 8'h00;
    left_x         = 8'h00;
    left_y         = 8'h00;
    right_x        = 8'h00;
    right_y        = 8'h00;
    trigger_left   = 8'h00;
    trigger_right  = 8'h00;
    typed_count    = PREDICTED;
    typed_reply    = 80'h0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Walk the directed table.
    for (row_idx = 0; row_idx < N_DIRECTED; row_idx++) begin
      row = directed_row(row_idx);
      send_item(row.op, row.rx, row.report, row.typed_n, row.typed);
    end

    while (useful_items < RANDOM_ITEMS) begin
      sender_idles = (useful_items / 40) % 3 != 2;
      if (!hold_done && useful_items >= 120) begin
        // Hold the output off and keep offering origin commands back to back
        // so the reply queue fills and the input stalls.
        hold_done = 1;
        long_hold_req = 1;
        no_gaps = 1;
        repeat (12) send_host_byte(jcr_pkg::CMD_ORIGIN);
        no_gaps = 0;
        useful_items += 12;
      end
      if (!drain_done && useful_items >= 260) begin
        // Pause until every owed reply byte is out.
        drain_done = 1;
        in_valid = 1'b0;
        while (pending_reply.size() != 0) @(negedge clk);
      end
      if (useful_items >= RANDOM_ITEMS - 60) steady_phase = 1;
      send_random_sequence();
    end
    in_valid = 1'b0;

    while (pending_reply.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
